// ===== hdl/deque_with_search_macros.svh =====
// Assertion macros shared by the deque_with_search RTL.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque_with_search: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque_with_search: next-cycle check failed");

`else

`define DWS_ASSERT_IMP(lbl, ante, cons)
`define DWS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/dws_pkg.sv =====
// Package: sizes, op codes, FSM states, payload types and ring helpers.
package dws_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [IDX_W:0]   CAP_EXT = (IDX_W+1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic             found;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] count;
  } out_t;

  // (base + off) mod CAPACITY, both operands below CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  // (base - 1) mod CAPACITY
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hdl/dws_ram.sv =====
// Generic simple dual-port RAM, registered read.
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dws_core.sv =====
// Sequencer, ring pointers and shared compare unit over the entry RAM.
`include "deque_with_search_macros.svh"

module dws_core
  import dws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic res_valid,
  input  logic res_ready,
  output out_t res
);

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  out_t                     res_r, res_nxt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [IDX_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     accept;
  logic                     match;
  logic                     last;

  assign accept = in_valid && in_ready;
  // idx_r names the entry whose read data is on ram_rdata this cycle
  assign match  = (ram_rdata == value_r);
  assign last   = ((CNT_W'(idx_r) + 1'b1) == count_r);

  dws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((op_r == OP_FIND) && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    op_nxt    = op_r;
    value_nxt = value_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = front_r;
    ram_raddr = front_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          op_nxt    = in_data.op;
          value_nxt = in_data.value;
        end
      end
      ST_EXEC: begin
        res_nxt = '{ok: 1'b0, found: 1'b0, position: '0, count: count_r};
        idx_nxt = '0;
        case (op_r)
          OP_PUSH_FRONT: begin
            if (count_r != CAP_CNT) begin
              front_nxt   = ring_dec(front_r);
              ram_we      = 1'b1;
              ram_waddr   = front_nxt;
              count_nxt   = count_r + 1'b1;
              res_nxt.ok  = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (count_r != '0) begin
              front_nxt  = ring_add(front_r, IDX_W'(1));
              count_nxt  = count_r - 1'b1;
              res_nxt.ok = 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (count_r != CAP_CNT) begin
              ram_we     = 1'b1;
              ram_waddr  = ring_add(front_r, count_r[IDX_W-1:0]);
              count_nxt  = count_r + 1'b1;
              res_nxt.ok = 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (count_r != '0) begin
              count_nxt  = count_r - 1'b1;
              res_nxt.ok = 1'b1;
            end
          end
          OP_FIND: begin
            // first read goes out now, lands in the first scan cycle
            ram_raddr  = front_r;
            res_nxt.ok = 1'b1;
          end
          default: begin
          end
        endcase
        res_nxt.count = count_nxt;
      end
      ST_SCAN: begin
        // compare one entry, fetch the next
        ram_raddr = ring_add(front_r, idx_r + 1'b1);
        if (match) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = idx_r;
        end else if (!last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
  end

  `DWS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CAP_CNT)
  `DWS_ASSERT_IMP(a_scan_in_range, state_r == ST_SCAN, (op_r == OP_FIND) && (CNT_W'(idx_r) < count_r))
  `DWS_ASSERT_IMP(a_found_ok, res_valid && res.found, res.ok)
  `DWS_ASSERT_NXT(a_idle_keeps_ring, (state_r == ST_IDLE) || (state_r == ST_SCAN), (front_r == $past(front_r)) && (count_r == $past(count_r)))

endmodule

// ===== hdl/deque_with_search.sv =====
// Top level: bounded deque with linear search, sequencer core plus output register.
//
//  channel | ports                         | direction | payload
//  --------+-------------------------------+-----------+---------------------------
//  input   | in_valid, in_ready, in_data   | in        | in_t  {op, value}
//  result  | out_valid, out_ready, out_data| out       | out_t {ok, found, position,
//          |                               |           |        count}
//
// Push, pop and unused op codes pass from acceptance to the result register
// through the states accept, execute and hand-off.
// Find adds a scan between execute and hand-off over n entries (none on an empty
// store, else 1 to count); the scan is paced by the single read port of the
// entry RAM, one entry a cycle.
// rst_n is synchronous; it clears the FSM, front index, count and output valid. RAM
// contents are not cleared: only held entries are ever compared.
// A finished result waits in the core while the output register is full and
// not being drained; no new transaction is taken until it moves out.
module deque_with_search
  import dws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic res_valid;
  logic res_ready;
  out_t res;

  dws_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // register takes a new result when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the deque_with_search block.
`timescale 1ns / 100ps

module testbench;
  import dws_pkg::*;

  // Op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

  localparam int RANDOM_PHASES = 40;
  localparam int PHASE_LEN = 50;
  localparam int DRAIN_CYCLES = 40;   // longest find plus hand-off, with margin

  typedef enum int {FILL_UP, DRAIN, MIXED, SEARCH} phase_mode_t;

  // One row of the directed table; reps > 1 repeats the op with value, value+1, ...
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic [4:0]        reps;
    logic              typed;
    out_t              res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t        pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned error_count = 0;
  bit          no_idle = 1'b0;

  // Predictor copy of the ring
  logic signed [DATA_W-1:0] ring_copy [CAPACITY];
  int front_copy = 0;
  int held_copy = 0;

  deque_with_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one op to the ring copy and returns what the block should report.
  function automatic out_t deque_apply(input in_t t);
    out_t r;
    r = '0;
    case (t.op)
      OP_PUSH_FRONT: begin
        if (held_copy < CAPACITY) begin
          front_copy = (front_copy + CAPACITY - 1) % CAPACITY;
          ring_copy[front_copy] = t.value;
          held_copy++;
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held_copy > 0) begin
          front_copy = (front_copy + 1) % CAPACITY;
          held_copy--;
          r.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (held_copy < CAPACITY) begin
          ring_copy[(front_copy + held_copy) % CAPACITY] = t.value;
          held_copy++;
          r.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held_copy > 0) begin
          held_copy--;
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        r.ok = 1'b1;
        // first match from the front wins
        for (int i = 0; i < held_copy; i++) begin
          if (!r.found && ring_copy[(front_copy + i) % CAPACITY] == t.value) begin
            r.found = 1'b1;
            r.position = IDX_W'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(held_copy);
    return r;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                         input int reps, input bit typed, input bit ok, input bit found,
                         input int pos, input int cnt);
    dir_row_t row;
    row.op = op;
    row.value = value;
    row.reps = 5'(reps);
    row.typed = typed;
    row.res.ok = ok;
    row.res.found = found;
    row.res.position = IDX_W'(pos);
    row.res.count = CNT_W'(cnt);
    dir_rows.push_back(row);
  endtask

  // Presents one transaction after a random gap and books its expected result
  // at the accepting edge.
  task automatic send_txn(input in_t t, input bit typed, input out_t typed_res);
    int gap;
    out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = deque_apply(t);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stimulus
  initial begin : stimulus
    in_t txn;
    out_t none;
    dir_row_t row;
    phase_mode_t mode;
    int unsigned roll;
    int unsigned pick;
    int push_pct;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    none = '0;

    // Directed table: empty pops, extremes, search hits and a miss, full pushes,
    // spare op codes, wrap of the front slot.
    add_row(OP_POP_FRONT,  '0,       1, 1, 0, 0, 0,  0);
    add_row(OP_POP_BACK,   '0,       1, 1, 0, 0, 0,  0);
    add_row(OP_FIND,       '0,       1, 1, 1, 0, 0,  0);
    add_row(OP_PUSH_BACK,  VAL_MAX,  1, 1, 1, 0, 0,  1);
    add_row(OP_PUSH_FRONT, VAL_MIN,  1, 1, 1, 0, 0,  2);
    add_row(OP_PUSH_BACK,  '0,       1, 1, 1, 0, 0,  3);
    add_row(OP_PUSH_FRONT, VAL_NEG1, 1, 1, 1, 0, 0,  4);
    add_row(OP_FIND,       VAL_NEG1, 1, 1, 1, 1, 0,  4);
    add_row(OP_FIND,       '0,       1, 1, 1, 1, 3,  4);
    add_row(OP_FIND,       VAL_MIN,  1, 1, 1, 1, 1,  4);
    add_row(OP_FIND,       32'd5,    1, 1, 1, 0, 0,  4);
    add_row(OP_SPARE_A,    '0,       1, 1, 0, 0, 0,  4);
    add_row(OP_SPARE_C,    VAL_NEG1, 1, 1, 0, 0, 0,  4);
    add_row(OP_POP_FRONT,  '0,       1, 1, 1, 0, 0,  3);
    add_row(OP_POP_BACK,   '0,       1, 1, 1, 0, 0,  2);
    add_row(OP_PUSH_BACK,  32'd100, 14, 0, 0, 0, 0,  0);   // fill to capacity
    add_row(OP_FIND,       32'd113,  1, 1, 1, 1, 15, 16);
    add_row(OP_FIND,       VAL_MAX,  1, 1, 1, 1, 1,  16);
    add_row(OP_PUSH_FRONT, 32'd7,    1, 1, 0, 0, 0,  16);
    add_row(OP_PUSH_BACK,  32'd7,    1, 1, 0, 0, 0,  16);
    add_row(OP_SPARE_B,    '0,       1, 0, 0, 0, 0,  0);
    add_row(OP_POP_BACK,   '0,       3, 0, 0, 0, 0,  0);
    add_row(OP_PUSH_FRONT, 32'd113,  1, 0, 0, 0, 0,  0);
    add_row(OP_FIND,       32'd113,  1, 1, 1, 1, 0,  14);
    add_row(OP_POP_FRONT,  '0,      14, 0, 0, 0, 0,  0);   // drain
    add_row(OP_POP_FRONT,  '0,       1, 1, 0, 0, 0,  0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        txn.op = row.op;
        txn.value = row.value + k;
        send_txn(txn, row.typed, row.res);
      end
    end

    // Random phases, each biased toward filling, draining, mixing or searching
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = phase_mode_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 3) == 0);
      case (mode)
        FILL_UP: push_pct = 80;
        DRAIN:   push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          txn.op = 3'($urandom_range(5, 7));
        end else if (roll < ((mode == SEARCH) ? 50 : 18)) begin
          txn.op = OP_FIND;
        end else if ($urandom_range(0, 99) < push_pct) begin
          txn.op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          txn.op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        end
        // small pool so searches hit, duplicates included
        pick = $urandom_range(0, 9);
        case (pick)
          0: txn.value = '0;
          1: txn.value = VAL_NEG1;
          2: txn.value = VAL_MIN;
          3: txn.value = VAL_MAX;
          4, 5, 6, 7: txn.value = DATA_W'($urandom_range(1, 6));
          default: txn.value = $urandom;
        endcase
        send_txn(txn, 1'b0, none);
      end
      // hold off until the block has handed back everything in flight
      if (p % 8 == 5) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, field-by-field compare with the oldest expectation
  initial begin : result_check
    int stall;
    out_t want;
    out_t got;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got = out_data;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: ok=%0b found=%0b pos=%0d cnt=%0d",
               got.ok, got.found, got.position, got.count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, got.ok);
          error_count++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, got.found);
          error_count++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, got.position);
          error_count++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, got.count);
          error_count++;
        end
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
